// ===== src/swpb_pkg.sv =====
// shared types and constants for the sliding window percent b block
`timescale 1ns / 1ps
package swpb_pkg;
	localparam int MaxWindow = 64;
	localparam int PriceBits = 24;
	localparam int SlotBits = 6;
	localparam int LenBits = 7;
	localparam int SumBits = 30;
	localparam int SqBits = 54;
	localparam int DevBits = 61;
	localparam logic [LenBits-1:0] LenReset = 7'd20;
	localparam logic signed [20:0] PbMax = 21'sd1048575;
	localparam logic signed [20:0] PbMin = -21'sd1048576;
	localparam logic signed [20:0] PbHalf = 21'sd32768;

	// controller commands to the datapath
	typedef struct packed {
		logic take;      // latch input item, start read of oldest entry
		logic update;    // update sums and ring
		logic prep;      // form deviation numerator
		logic div_start; // start a divide
		logic div_sel;   // 0: mean/var, 1: percent
		logic div_step;
		logic sqrt_start;
		logic sqrt_step;
		logic finish;    // build result
	} swpb_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
	} swpb_sts_t;
endpackage

// ===== src/swpb_ram.sv =====
// generic single port ram with registered read
`timescale 1ns / 1ps
module swpb_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// ===== src/swpb_datapath.sv =====
// window sums, ring memory, shared divider and square root
`timescale 1ns / 1ps
module swpb_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  swpb_pkg::swpb_cmd_t                 cmd,
	output swpb_pkg::swpb_sts_t                 sts,
	input  logic                                cfg_we,
	input  logic [swpb_pkg::LenBits-1:0]        cfg_data,
	input  logic [swpb_pkg::PriceBits-1:0]      in_price,
	input  logic                                in_restart,
	output logic [swpb_pkg::PriceBits-1:0]      mean_price,
	output logic [swpb_pkg::PriceBits-1:0]      std_dev,
	output logic signed [20:0]                  band_pos,
	output logic                                window_full
);
	localparam int DB = swpb_pkg::DevBits;
	logic [swpb_pkg::LenBits-1:0] len_q, fill_q, n_q;
	logic [swpb_pkg::SlotBits-1:0] slot_q;
	logic [swpb_pkg::SumBits-1:0] sum_q;
	logic [swpb_pkg::SqBits-1:0] sq_q;
	logic [swpb_pkg::PriceBits-1:0] p_q, old;
	logic full_now_q, restart_q, full_q;
	logic [47:0] p_sq, old_sq;
	logic [DB-1:0] dev_q;
	// divider
	logic [DB-1:0] dvd_q, quo_q;
	logic [DB:0] rem_q;
	logic [23:0] dvs_q;
	logic [6:0] dcnt_q;
	logic [DB:0] rem_try;
	// square root
	logic [63:0] sx_q, sres_q, sbit_q;
	logic [5:0] scnt_q;
	logic [1:0] div_phase_q;
	logic [swpb_pkg::PriceBits-1:0] mean_q, s_q;
	logic [13:0] nn;
	// numerator p - m + 2s
	logic signed [27:0] num;
	logic [26:0] percent_mag;

	// fill_count after restart gives effective history
	logic [swpb_pkg::LenBits-1:0] fill_eff;
	logic [swpb_pkg::SlotBits-1:0] slot_eff;
	assign fill_eff = restart_q ? '0 : fill_q;
	assign slot_eff = restart_q ? '0 : slot_q;

	swpb_ram #(.Width(swpb_pkg::PriceBits), .Depth(swpb_pkg::MaxWindow)) u_ring (
		.clk(clk), .we(cmd.update), .addr(slot_eff), .wdata(p_q), .rdata(old)
	);

	assign p_sq = p_q * p_q;
	assign old_sq = old * old;
	assign nn = n_q * n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= swpb_pkg::LenReset;
			fill_q <= '0; slot_q <= '0; sum_q <= '0; sq_q <= '0;
		end else if (cfg_we) begin
			len_q <= (cfg_data < 7'd2) ? 7'd2 :
				(cfg_data > 7'(swpb_pkg::MaxWindow)) ? 7'(swpb_pkg::MaxWindow) : cfg_data;
			fill_q <= '0; slot_q <= '0; sum_q <= '0; sq_q <= '0;
		end else if (cmd.update) begin
			if (full_now_q) begin
				sum_q <= sum_q - 30'(old) + 30'(p_q);
				sq_q <= sq_q - 54'(old_sq) + 54'(p_sq);
			end else begin
				sum_q <= (restart_q ? '0 : sum_q) + 30'(p_q);
				sq_q <= (restart_q ? '0 : sq_q) + 54'(p_sq);
				fill_q <= fill_eff + 7'd1;
			end
			slot_q <= (7'(slot_eff) + 7'd1 >= len_q) ? '0 : slot_eff + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			p_q <= in_price;
			restart_q <= in_restart;
		end
		if (cmd.update) begin
			n_q <= full_now_q ? fill_q : fill_eff + 7'd1;
			full_q <= full_now_q || (fill_eff + 7'd1 >= len_q);
		end
		if (cmd.prep)
			dev_q <= DB'(n_q * sq_q) - DB'(sum_q * sum_q);
	end
	// full flag from state before update, cleared on take and loaded in the read state
	always_ff @(posedge clk) begin
		if (cmd.take) full_now_q <= 1'b0;
		else if (!cmd.update) full_now_q <= (fill_eff >= len_q);
	end

	assign num = 28'(p_q) - 28'(mean_q) + (28'(s_q) << 1);
	assign percent_mag = num[27] ? 27'(-num) : 27'(num);

	// restoring divider, one quotient bit a cycle while div_step is high
	assign rem_try = {rem_q[DB-1:0], dvd_q[DB-1]} - {{(DB-23){1'b0}}, dvs_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0; div_phase_q <= '0;
		end else if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= '0;
			dcnt_q <= 7'(DB);
			if (cmd.div_sel) begin
				dvd_q <= DB'(percent_mag) << 14;
				dvs_q <= s_q;
			end else if (div_phase_q == 2'd0) begin
				dvd_q <= DB'(sum_q);
				dvs_q <= 24'(n_q);
			end else begin
				dvd_q <= dev_q;
				dvs_q <= 24'(nn);
			end
		end else if (cmd.div_step && dcnt_q != '0) begin
			if (!rem_try[DB]) begin
				rem_q <= rem_try; quo_q <= {quo_q[DB-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DB-1:0], dvd_q[DB-1]}; quo_q <= {quo_q[DB-2:0], 1'b0};
			end
			dvd_q <= {dvd_q[DB-2:0], 1'b0};
			dcnt_q <= dcnt_q - 7'd1;
			if (dcnt_q == 7'd1 && !cmd.div_sel) begin
				div_phase_q <= div_phase_q + 2'd1;
				if (div_phase_q == 2'd0) mean_q <= 24'(quo_q << 1 | DB'(!rem_try[DB]));
			end
		end else if (cmd.finish) begin
			div_phase_q <= '0;
		end
	end
	assign sts.div_done = (dcnt_q == '0);

	// bitwise square root, stepped while sqrt_step is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scnt_q <= '0;
		end else if (cmd.sqrt_start) begin
			sx_q <= 64'(quo_q);
			sres_q <= '0;
			sbit_q <= 64'd1 << 62;
			scnt_q <= 6'd32;
		end else if (cmd.sqrt_step && scnt_q != '0) begin
			if (sx_q >= sres_q + sbit_q) begin
				sx_q <= sx_q - (sres_q + sbit_q);
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
			scnt_q <= scnt_q - 6'd1;
			if (scnt_q == 6'd1) s_q <= 24'(sx_q >= sres_q + sbit_q ?
				(sres_q >> 1) + sbit_q : sres_q >> 1);
		end
	end
	assign sts.sqrt_done = (scnt_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			mean_price <= mean_q;
			std_dev <= s_q;
			window_full <= full_q;
			if (s_q == '0) band_pos <= swpb_pkg::PbHalf;
			else if (num[27])
				band_pos <= (quo_q > DB'(1048576)) ? swpb_pkg::PbMin : -21'(quo_q);
			else
				band_pos <= (quo_q > DB'(1048575)) ? swpb_pkg::PbMax : 21'(quo_q);
		end
	end
endmodule

// ===== src/swpb_ctrl.sv =====
// sequencer for one item
`timescale 1ns / 1ps
module swpb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                out_free,
	input  swpb_pkg::swpb_sts_t sts,
	output swpb_pkg::swpb_cmd_t cmd,
	output logic                busy,
	output logic                done
);
	localparam logic [3:0] S_IDLE = 4'd0, S_READ = 4'd1, S_UPD = 4'd2, S_PREP = 4'd3,
		S_D0 = 4'd4, S_D0W = 4'd5, S_D1 = 4'd6, S_D1W = 4'd7, S_SQ = 4'd8,
		S_SQW = 4'd9, S_D2 = 4'd10, S_D2W = 4'd11, S_FIN = 4'd12, S_OUT = 4'd13;
	logic [3:0] st_q, st_d;
	always_comb begin
		cmd = '0;
		st_d = st_q;
		unique case (st_q)
			S_IDLE: if (in_fire) begin cmd.take = 1'b1; st_d = S_READ; end
			S_READ: st_d = S_UPD;
			S_UPD: begin cmd.update = 1'b1; st_d = S_PREP; end
			S_PREP: begin cmd.prep = 1'b1; st_d = S_D0; end
			S_D0: begin cmd.div_start = 1'b1; st_d = S_D0W; end
			S_D0W: begin cmd.div_step = 1'b1; if (sts.div_done) st_d = S_D1; end
			S_D1: begin cmd.div_start = 1'b1; st_d = S_D1W; end
			S_D1W: begin cmd.div_step = 1'b1; if (sts.div_done) st_d = S_SQ; end
			S_SQ: begin cmd.sqrt_start = 1'b1; st_d = S_SQW; end
			S_SQW: begin cmd.sqrt_step = 1'b1; if (sts.sqrt_done) st_d = S_D2; end
			S_D2: begin cmd.div_start = 1'b1; cmd.div_sel = 1'b1; st_d = S_D2W; end
			S_D2W: begin
				cmd.div_step = 1'b1; cmd.div_sel = 1'b1;
				if (sts.div_done) st_d = S_FIN;
			end
			S_FIN: if (out_free) begin cmd.finish = 1'b1; st_d = S_OUT; end
			S_OUT: st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end
	assign busy = (st_q != S_IDLE);
	assign done = (st_q == S_OUT);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_IDLE;
		else st_q <= st_d;
	end
endmodule

// ===== src/sliding_window_percent_b.sv =====
// top level of the sliding window bollinger percent b block
`timescale 1ns / 1ps
// Bollinger %B over a sliding window of up to 64 Q16.8 prices. One item is
// taken at a time and handled in order: read the oldest entry, update the sums
// and form the variance numerator; the mean and variance quotients on the
// shared restoring divider (start, steps, done check); the square root (start,
// steps, done check); the percent quotient on the divider; then load the
// output register and raise m_axis_tvalid. A new item is accepted only once
// the sequencer has returned to idle. The result sits in the output register
// while the next item is accepted; if it has still not left when the next
// result is ready, the sequencer waits and the input stalls. Writing the
// window length clears the history, as does the restart bit of an item.
module sliding_window_percent_b (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_data,       // window_length
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // price
	input  logic        s_axis_tuser,   // restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // mean_price, std_dev, band_pos, zero pad
	output logic        m_axis_tuser    // window_full
);
	swpb_pkg::swpb_cmd_t cmd;
	swpb_pkg::swpb_sts_t sts;
	logic busy, done, in_fire, out_free;
	logic [23:0] mean_price, std_dev;
	logic signed [20:0] band_pos;
	logic window_full;

	// take a new item only with the sequencer idle
	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	// the output register may be reloaded once its item has left
	assign out_free = !m_axis_tvalid || m_axis_tready;

	swpb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.sts(sts), .cmd(cmd), .busy(busy), .done(done)
	);

	swpb_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_price(s_axis_tdata), .in_restart(s_axis_tuser),
		.mean_price(mean_price), .std_dev(std_dev), .band_pos(band_pos),
		.window_full(window_full)
	);

	// result valid flag, set once the output register is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (done) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end
	assign m_axis_tdata = {3'b000, band_pos, std_dev, mean_price};
	assign m_axis_tuser = window_full;

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready) else $error("item taken while busy");
	a_done_sets: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> m_axis_tvalid) else $error("result lost");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.update, cmd.finish})) else $error("command clash");
endmodule
